// File: rtl/core/nfae_pkg.sv
// Shared types and constants of the epsilon-NFA acceptor.
`timescale 1ns / 1ps
package nfae_pkg;

    localparam int MODE_W     = 2;
    localparam int STATE_W    = 4;
    localparam int SYM_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int FINAL_W    = 16;

    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_mode MODE_LOAD   = 2'd0;
    localparam t_mode MODE_SYMBOL = 2'd1;
    localparam t_mode MODE_END    = 2'd2;

    localparam t_cfg_idx CFG_START_STATE  = 1'd0;
    localparam t_cfg_idx CFG_FINAL_STATES = 1'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD_WR,
        ST_SWEEP,
        ST_REPORT
    } t_state;

    typedef enum logic {
        PH_MOVE,
        PH_CLOSE
    } t_phase;

    typedef struct packed {
        logic [STATE_W-1:0] start_state;
        logic [FINAL_W-1:0] final_states;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic accepted;
    } t_result;

endpackage

// File: rtl/core/nfae_item_if.sv
// Input channel of the acceptor: transition loads, symbols and end marks.
`timescale 1ns / 1ps
interface nfae_item_if import nfae_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [STATE_W-1:0] from_state;
    logic [SYM_W-1:0]   symbol;
    logic [STATE_W-1:0] to_state;

    modport source (output valid, mode, from_state, symbol, to_state, input ready);
    modport sink   (input valid, mode, from_state, symbol, to_state, output ready);
endinterface

// File: rtl/core/nfae_result_if.sv
// Result channel of the acceptor: one verdict per finished string.
`timescale 1ns / 1ps
interface nfae_result_if import nfae_pkg::*;
();
    logic valid;
    logic ready;
    logic accepted;

    modport source (output valid, accepted, input ready);
    modport sink   (input valid, accepted, output ready);
endinterface

// File: rtl/core/nfae_row_ram.sv
// Transition row memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module nfae_row_ram #(
    parameter int DEPTH = 432,
    parameter int WIDTH = 16,
    parameter int AW    = 9
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/nfae_ctrl.sv
// Sequencer: clears the row memory, loads transitions, moves and closes the active set.
`timescale 1ns / 1ps
module nfae_ctrl import nfae_pkg::*; #(
    parameter int NUM_STATES  = 16,
    parameter int NUM_SYMBOLS = 27,
    parameter int DEPTH       = NUM_STATES * NUM_SYMBOLS,
    parameter int AW          = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    nfae_item_if.sink             i_item,
    input  t_cfg                  i_cfg,
    output t_result               o_res,
    input  logic                  i_res_ready,
    output logic                  o_ram_we,
    output logic [AW-1:0]         o_ram_waddr,
    output logic [NUM_STATES-1:0] o_ram_wdata,
    output logic [AW-1:0]         o_ram_raddr,
    input  logic [NUM_STATES-1:0] i_ram_rdata
);

    localparam int SW     = $clog2(NUM_STATES);
    localparam int LAMBDA = NUM_SYMBOLS - 1;

    t_state                r_state,    n_state;
    t_phase                r_phase,    n_phase;
    logic [AW-1:0]         r_clr_addr, n_clr_addr;
    logic                  r_fresh,    n_fresh;
    logic [NUM_STATES-1:0] r_set,      n_set;
    logic                  r_rdv,      n_rdv;
    logic [NUM_STATES-1:0] r_acc,      n_acc;
    logic [NUM_STATES-1:0] r_pend,     n_pend;
    logic [NUM_STATES-1:0] r_done,     n_done;
    logic [AW-1:0]         r_addr,     n_addr;
    logic [STATE_W-1:0]    r_to,       n_to;
    logic [SYM_W-1:0]      r_sym,      n_sym;
    logic                  r_mode_end, n_mode_end;
    logic                  r_move_nxt, n_move_nxt;

    logic [NUM_STATES-1:0] merged;
    logic [NUM_STATES-1:0] pend;
    logic [SW-1:0]         pick;
    logic                  any_pend;
    logic [NUM_STATES-1:0] seed;
    logic [NUM_STATES-1:0] final_mask;
    logic [AW-1:0]         load_addr;
    logic [AW-1:0]         sweep_addr;
    logic                  load_ok;
    logic                  move_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_fresh    <= 1'b1;
            r_set      <= '0;
            r_rdv      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_fresh    <= n_fresh;
            r_set      <= n_set;
            r_rdv      <= n_rdv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase    <= n_phase;
        r_acc      <= n_acc;
        r_pend     <= n_pend;
        r_done     <= n_done;
        r_addr     <= n_addr;
        r_to       <= n_to;
        r_sym      <= n_sym;
        r_mode_end <= n_mode_end;
        r_move_nxt <= n_move_nxt;
    end

    // Row data of the read issued last cycle joins the collected set here.
    assign merged = r_acc | (r_rdv ? i_ram_rdata : '0);
    assign pend   = (r_phase == PH_CLOSE) ? (merged & ~r_done) : r_pend;
    assign any_pend = |pend;

    always_comb begin
        pick = '0;
        for (int i = NUM_STATES - 1; i >= 0; i--) begin
            if (pend[i]) begin
                pick = SW'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_STATES; i++) begin
            final_mask[i] = (i < FINAL_W) ? i_cfg.final_states[i % FINAL_W] : 1'b0;
        end
    end

    assign seed = (int'(i_cfg.start_state) < NUM_STATES)
                ? (NUM_STATES'(1) << i_cfg.start_state) : '0;

    assign load_addr  = AW'(int'(i_item.from_state) * NUM_SYMBOLS + int'(i_item.symbol));
    assign sweep_addr = AW'(int'(pick) * NUM_SYMBOLS
                          + ((r_phase == PH_CLOSE) ? LAMBDA : int'(r_sym)));

    assign load_ok = (int'(i_item.from_state) < NUM_STATES)
                  && (int'(i_item.to_state) < NUM_STATES)
                  && (int'(i_item.symbol) < NUM_SYMBOLS);
    assign move_ok = (i_item.mode == MODE_SYMBOL) && (int'(i_item.symbol) < LAMBDA);

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_clr_addr  = r_clr_addr;
        n_fresh     = r_fresh;
        n_set       = r_set;
        n_rdv       = r_rdv;
        n_acc       = r_acc;
        n_pend      = r_pend;
        n_done      = r_done;
        n_addr      = r_addr;
        n_to        = r_to;
        n_sym       = r_sym;
        n_mode_end  = r_mode_end;
        n_move_nxt  = r_move_nxt;
        i_item.ready = 1'b0;
        o_res       = '0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_addr;
        o_ram_wdata = '0;
        o_ram_raddr = '0;

        case (r_state)
            ST_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_clr_addr;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end
            ST_IDLE: begin
                i_item.ready = 1'b1;
                o_ram_raddr  = load_addr;
                if (i_item.valid) begin
                    case (i_item.mode)
                        MODE_LOAD: begin
                            if (load_ok) begin
                                n_addr  = load_addr;
                                n_to    = i_item.to_state;
                                n_state = ST_LOAD_WR;
                            end
                        end
                        MODE_SYMBOL, MODE_END: begin
                            n_mode_end = (i_item.mode == MODE_END);
                            n_sym      = i_item.symbol;
                            n_rdv      = 1'b0;
                            if (r_fresh) begin
                                // close the start state first, then move if asked
                                n_fresh    = 1'b0;
                                n_phase    = PH_CLOSE;
                                n_acc      = seed;
                                n_done     = '0;
                                n_move_nxt = move_ok;
                                n_state    = ST_SWEEP;
                            end else if (move_ok) begin
                                n_phase    = PH_MOVE;
                                n_pend     = r_set;
                                n_acc      = '0;
                                n_move_nxt = 1'b0;
                                n_state    = ST_SWEEP;
                            end else if (i_item.mode == MODE_END) begin
                                n_state = ST_REPORT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOAD_WR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_addr;
                o_ram_wdata = i_ram_rdata | (NUM_STATES'(1) << r_to);
                n_state     = ST_IDLE;
            end
            ST_SWEEP: begin
                o_ram_raddr = sweep_addr;
                n_acc       = merged;
                if (any_pend) begin
                    n_rdv = 1'b1;
                    if (r_phase == PH_MOVE) begin
                        n_pend[pick] = 1'b0;
                    end else begin
                        n_done[pick] = 1'b1;
                    end
                end else begin
                    n_rdv = 1'b0;
                    if (r_phase == PH_MOVE) begin
                        n_phase = PH_CLOSE;
                        n_done  = '0;
                    end else begin
                        n_set = merged;
                        if (r_move_nxt) begin
                            n_move_nxt = 1'b0;
                            n_phase    = PH_MOVE;
                            n_pend     = merged;
                            n_acc      = '0;
                        end else if (r_mode_end) begin
                            n_state = ST_REPORT;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_REPORT: begin
                o_res.valid    = 1'b1;
                o_res.accepted = |(r_set & final_mask);
                if (i_res_ready) begin
                    n_fresh = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/nfa_epsilon_acceptor_core.sv
// Top level of the epsilon-NFA acceptor: config registers, row memory, sequencer, output register.
//
// Acceptor for a nondeterministic automaton with lambda moves. Transitions are kept as one
// NUM_STATES-bit destination mask per (state, symbol) row in a single-port-read memory of
// NUM_STATES*NUM_SYMBOLS rows. After reset a clearing pass writes every row to zero, one row
// per cycle; no item is taken during it, but configuration writes are. A load reads its row,
// then writes it back with the new destination bit set. A symbol reads one row per active
// state, then one lambda row per state of the closure, one read per cycle; the first symbol
// or end mark of a string first computes the start closure. An end mark's verdict sits in an
// output register, so the next item is taken while it waits.
`timescale 1ns / 1ps
module nfa_epsilon_acceptor_core import nfae_pkg::*; #(
    parameter int NUM_STATES  = 16,
    parameter int NUM_SYMBOLS = 27
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    nfae_item_if.sink             i_item,
    nfae_result_if.source         o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH = NUM_STATES * NUM_SYMBOLS;
    localparam int AW    = $clog2(DEPTH);

    logic [STATE_W-1:0]    r_start_state;
    logic [FINAL_W-1:0]    r_final_states;
    logic                  r_out_vld;
    logic                  r_out_acc;

    t_cfg                  cfg;
    t_result               res;
    logic                  res_ready;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [NUM_STATES-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [NUM_STATES-1:0] ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_state  <= '0;
            r_final_states <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_STATE:  r_start_state  <= i_cfg_data[STATE_W-1:0];
                CFG_FINAL_STATES: r_final_states <= i_cfg_data[FINAL_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.start_state  = r_start_state;
    assign cfg.final_states = r_final_states;

    // Hold the verdict until the sink takes the transfer.
    assign res_ready = !r_out_vld || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_ready) begin
            r_out_vld <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res.valid) begin
            r_out_acc <= res.accepted;
        end
    end

    assign o_result.valid    = r_out_vld;
    assign o_result.accepted = r_out_acc;

    nfae_row_ram #(
        .DEPTH (DEPTH),
        .WIDTH (NUM_STATES),
        .AW    (AW)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    nfae_ctrl #(
        .NUM_STATES  (NUM_STATES),
        .NUM_SYMBOLS (NUM_SYMBOLS),
        .DEPTH       (DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg       (cfg),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

endmodule

// File: test/nfa_epsilon_acceptor_core_tb.sv
// Self-checking bench for the epsilon-NFA acceptor: random automata, strings and stalls.
`timescale 1ns / 1ps
module nfa_epsilon_acceptor_core_tb;
    import nfae_pkg::*;

    localparam int NUM_STATES    = 16;
    localparam int NUM_SYMS      = 27;
    localparam int SYM_LAMBDA    = NUM_SYMS - 1;
    localparam t_mode MODE_NONE  = 2'd3;
    localparam int SETTLE_CYCLES = 80;
    localparam int ITEM_TARGET   = 1450;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    t_cfg_idx              i_cfg_idx  = CFG_START_STATE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    nfae_item_if   item_ch ();
    nfae_result_if verdict_ch ();

    nfa_epsilon_acceptor_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_result   (verdict_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Automaton copy: one destination mask per (state, symbol) row.
    bit [NUM_STATES-1:0] trans_rows [NUM_STATES*NUM_SYMS];
    bit [NUM_STATES-1:0] live_set;
    bit                  fresh_string = 1'b1;
    bit [STATE_W-1:0]    cfg_start;
    bit [FINAL_W-1:0]    cfg_finals;
    bit                  verdicts_due [$];
    bit                  want_verdict;

    int fail_count;
    int items_sent;
    bit tx_bursty = 1'b1;
    int tx_burst_left;
    int rx_hold_req;
    int rx_hold_left;
    int rx_run_left;
    int rx_style;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit [NUM_STATES-1:0] step_set(bit [NUM_STATES-1:0] states, int sym);
        bit [NUM_STATES-1:0] reached = '0;
        for (int s = 0; s < NUM_STATES; s++)
            if (states[s])
                reached |= trans_rows[s*NUM_SYMS + sym];
        return reached;
    endfunction

    function automatic bit [NUM_STATES-1:0] close_set(bit [NUM_STATES-1:0] states);
        bit [NUM_STATES-1:0] grown;
        for (int pass_no = 0; pass_no < NUM_STATES; pass_no++) begin
            grown = states | step_set(states, SYM_LAMBDA);
            if (grown == states)
                break;
            states = grown;
        end
        return states;
    endfunction

    function automatic bit [NUM_STATES-1:0] start_closure();
        return close_set(16'd1 << cfg_start);
    endfunction

    // Prefer letters that keep the active set alive so strings walk the automaton.
    function automatic logic [SYM_W-1:0] pick_letter();
        bit [NUM_STATES-1:0] cur;
        int base;
        cur  = fresh_string ? start_closure() : live_set;
        base = $urandom_range(0, SYM_LAMBDA - 1);
        if ($urandom_range(0, 3) != 0)
            for (int k = 0; k < SYM_LAMBDA; k++)
                if (step_set(cur, (base + k) % SYM_LAMBDA) != 0)
                    return SYM_W'((base + k) % SYM_LAMBDA);
        return SYM_W'(base);
    endfunction

    task automatic predict_item(t_mode m, logic [STATE_W-1:0] src, logic [SYM_W-1:0] sym,
                                logic [STATE_W-1:0] dst);
        if ((m == MODE_SYMBOL || m == MODE_END) && fresh_string) begin
            live_set     = start_closure();
            fresh_string = 1'b0;
        end
        case (m)
            MODE_LOAD: begin
                if (sym < NUM_SYMS)
                    trans_rows[int'(src)*NUM_SYMS + int'(sym)][dst] = 1'b1;
            end
            MODE_SYMBOL: begin
                if (sym < SYM_LAMBDA)
                    live_set = close_set(step_set(live_set, int'(sym)));
            end
            MODE_END: begin
                verdicts_due.push_back((live_set & cfg_finals) != 0);
                fresh_string = 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic send_item(t_mode m, logic [STATE_W-1:0] src, logic [SYM_W-1:0] sym,
                             logic [STATE_W-1:0] dst);
        int gap;
        if (tx_bursty) begin
            if (tx_burst_left == 0) begin
                tx_burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0) begin
                    item_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            tx_burst_left--;
        end
        item_ch.valid      <= 1'b1;
        item_ch.mode       <= m;
        item_ch.from_state <= src;
        item_ch.symbol     <= sym;
        item_ch.to_state   <= dst;
        do @(posedge i_clk); while (item_ch.ready !== 1'b1);
        predict_item(m, src, sym, dst);
        items_sent++;
    endtask

    task automatic send_random_load();
        logic [SYM_W-1:0] sym;
        sym = ($urandom_range(0, 15) == 0) ? SYM_W'(SYM_LAMBDA)
                                           : SYM_W'($urandom_range(0, SYM_LAMBDA - 1));
        send_item(MODE_LOAD, STATE_W'($urandom), sym, STATE_W'($urandom));
    endtask

    task automatic set_regs(bit [STATE_W-1:0] start, bit [FINAL_W-1:0] finals);
        logic [CFG_DATA_W-STATE_W-1:0] junk;
        junk = (CFG_DATA_W-STATE_W)'($urandom);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_START_STATE;
        i_cfg_data <= {junk, start};
        @(posedge i_clk);
        cfg_start = start;
        i_cfg_idx  <= CFG_FINAL_STATES;
        i_cfg_data <= finals;
        @(posedge i_clk);
        cfg_finals = finals;
        i_cfg_we   <= 1'b0;
    endtask

    // Wait out every pending verdict, then give a trailing symbol time to finish.
    task automatic drain_and_pause();
        item_ch.valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed_paths();
        set_regs(4'd3, 16'h0008);
        send_item(MODE_END, 4'd0, 5'd0, 4'd0);
        send_item(MODE_LOAD, 4'd3, 5'd0, 4'd5);
        send_item(MODE_LOAD, 4'd5, SYM_W'(SYM_LAMBDA), 4'd7);
        send_item(MODE_LOAD, 4'd7, 5'd25, 4'd15);
        send_item(MODE_LOAD, 4'd15, SYM_W'(SYM_LAMBDA), 4'd0);
        send_item(MODE_LOAD, 4'd0, 5'd27, 4'd9);
        send_item(MODE_LOAD, 4'd15, 5'd31, 4'd15);
        send_item(MODE_SYMBOL, 4'd0, 5'd0, 4'd0);
        send_item(MODE_SYMBOL, 4'd0, SYM_W'(SYM_LAMBDA), 4'd0);
        send_item(MODE_NONE, 4'd15, 5'd31, 4'd15);
        send_item(MODE_END, 4'd15, 5'd31, 4'd15);
        // out-of-range letter still opens the string
        send_item(MODE_SYMBOL, 4'd0, 5'd31, 4'd0);
        send_item(MODE_END, 4'd0, 5'd0, 4'd0);
        send_item(MODE_SYMBOL, 4'd0, 5'd0, 4'd0);
        send_item(MODE_SYMBOL, 4'd0, 5'd25, 4'd0);
        send_item(MODE_END, 4'd0, 5'd0, 4'd0);
        // transition added mid-string applies from the next letter
        send_item(MODE_SYMBOL, 4'd0, 5'd0, 4'd0);
        send_item(MODE_LOAD, 4'd7, 5'd1, 4'd3);
        send_item(MODE_SYMBOL, 4'd0, 5'd1, 4'd0);
        send_item(MODE_END, 4'd0, 5'd0, 4'd0);
        send_item(MODE_LOAD, 4'd0, SYM_W'(SYM_LAMBDA), 4'd3);
        send_item(MODE_SYMBOL, 4'd0, 5'd0, 4'd0);
        send_item(MODE_SYMBOL, 4'd0, 5'd25, 4'd0);
        send_item(MODE_END, 4'd0, 5'd0, 4'd0);
    endtask

    task automatic test_register_extremes();
        drain_and_pause();
        set_regs(4'd15, 16'hFFFF);
        send_item(MODE_END, 4'd0, 5'd0, 4'd0);
        drain_and_pause();
        set_regs(4'd0, 16'h0000);
        send_item(MODE_END, 4'd0, 5'd0, 4'd0);
        drain_and_pause();
        set_regs(4'd15, 16'h8000);
        send_item(MODE_END, 4'd0, 5'd0, 4'd0);
    endtask

    // Hold the verdict channel while ends keep coming so the input backs up.
    task automatic test_output_stall();
        drain_and_pause();
        set_regs(4'd3, 16'h00A9);
        rx_hold_req = 400;
        tx_bursty   = 1'b0;
        repeat (12) begin
            if ($urandom_range(0, 1) != 0)
                send_item(MODE_SYMBOL, 4'd0, pick_letter(), 4'd0);
            send_item(MODE_END, 4'd0, 5'd0, 4'd0);
        end
        tx_bursty = 1'b1;
    endtask

    task automatic test_random_strings();
        int phase_no;
        int len;
        bit [FINAL_W-1:0] finals;
        bit [STATE_W-1:0] start;
        phase_no = 0;
        while (items_sent < ITEM_TARGET) begin
            drain_and_pause();
            case (phase_no % 6)
                0: finals = 16'hFFFF;
                1: finals = 16'h0000;
                default: begin
                    finals = '0;
                    repeat ($urandom_range(1, 4)) finals[$urandom_range(0, 15)] = 1'b1;
                end
            endcase
            if (phase_no % 7 == 3)
                start = 4'd15;
            else if (phase_no % 7 == 5)
                start = 4'd0;
            else
                start = STATE_W'($urandom);
            set_regs(start, finals);
            repeat ($urandom_range(0, 3)) send_random_load();
            repeat ($urandom_range(4, 10)) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 6);
                repeat (len) begin
                    case ($urandom_range(0, 39))
                        0: send_item(MODE_NONE, STATE_W'($urandom), SYM_W'($urandom),
                                     STATE_W'($urandom));
                        1: send_item(MODE_LOAD, STATE_W'($urandom),
                                     SYM_W'($urandom_range(NUM_SYMS, 31)), STATE_W'($urandom));
                        2: send_item(MODE_SYMBOL, STATE_W'($urandom),
                                     SYM_W'($urandom_range(SYM_LAMBDA, 31)), STATE_W'($urandom));
                        3: send_random_load();
                        default: send_item(MODE_SYMBOL, STATE_W'($urandom), pick_letter(),
                                           STATE_W'($urandom));
                    endcase
                end
                // now and then leave the string open so it runs into the next one
                if ($urandom_range(0, 11) != 0)
                    send_item(MODE_END, STATE_W'($urandom), SYM_W'($urandom),
                              STATE_W'($urandom));
            end
            phase_no++;
        end
    endtask

    always @(posedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left != 0) begin
            verdict_ch.ready <= 1'b0;
            rx_hold_left--;
        end else begin
            if (rx_run_left == 0) begin
                rx_style    = $urandom_range(0, 2);
                rx_run_left = $urandom_range(8, 80);
            end
            rx_run_left--;
            case (rx_style)
                0:       verdict_ch.ready <= 1'b1;
                1:       verdict_ch.ready <= ($urandom_range(0, 3) != 0);
                default: verdict_ch.ready <= ((rx_run_left % 5) < 2);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && verdict_ch.valid === 1'b1 && verdict_ch.ready === 1'b1) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: verdict transfer with none pending, expected none, got %0b",
                         $time, verdict_ch.accepted);
                fail_count++;
            end else begin
                want_verdict = verdicts_due.pop_front();
                if (verdict_ch.accepted !== want_verdict) begin
                    $display("%0t: accepted mismatch, expected %0b, got %0b",
                             $time, want_verdict, verdict_ch.accepted);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        item_ch.valid      = 1'b0;
        item_ch.mode       = MODE_LOAD;
        item_ch.from_state = '0;
        item_ch.symbol     = '0;
        item_ch.to_state   = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_paths();
        test_register_extremes();
        test_output_stall();
        test_random_strings();
        drain_and_pause();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
